[hdl/rla_pkg.sv]
// ----------------------------------------------------------------------------
// rla_pkg: shared definitions of the regression loss accumulator
// Widths, limits, register indexes, sequencer states and the structs that
// connect the configuration block and the shared arithmetic units.
// ----------------------------------------------------------------------------
package rla_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COUNT_WIDTH = 32;

  localparam int DATA_W  = 32;
  localparam int THR_W   = 31;
  localparam int BATCH_W = 16;
  localparam int SUM_W   = 64;
  localparam int LOSS_W  = 48;
  localparam int NORM_W  = 32;

  localparam int MUL_AW = DATA_W + 1;
  localparam int MUL_BW = DATA_W;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int XM_W   = MUL_PW - FRAC_BITS;

  localparam int DIV_NW = (SUM_W + BATCH_W > COUNT_WIDTH + 1 + FRAC_BITS) ?
                          (SUM_W + BATCH_W) : (COUNT_WIDTH + 1 + FRAC_BITS);
  localparam int DIV_DW    = COUNT_WIDTH + 1;
  localparam int DIV_CNT_W = $clog2(DIV_NW + 1);

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  localparam logic [LOSS_W-1:0] LOSS_MAX = {LOSS_W{1'b1}};
  localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};
  localparam logic [NORM_W-1:0] ONE_Q    = NORM_W'(1) << FRAC_BITS;
  localparam logic [NORM_W-1:0] NF_LIMIT = NORM_MAX >> FRAC_BITS;

  localparam logic [1:0] NORM_NONE = 2'd0;
  localparam logic [1:0] NORM_ELEM = 2'd1;
  localparam logic [1:0] NORM_POS  = 2'd2;

  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_GAIN      = 3'd1,
    REG_SMOOTH    = 3'd2,
    REG_NORM      = 3'd3,
    REG_BATCH     = 3'd4,
    REG_POS_SRC   = 3'd5
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MASK,
    S_MUL1,
    S_MUL2,
    S_ACC,
    S_DIV_SUM,
    S_WAIT_SUM,
    S_DIV_EX,
    S_WAIT_EX,
    S_DIV_L,
    S_WAIT_L,
    S_MUL_LO,
    S_MUL_HI,
    S_DIV_P,
    S_WAIT_P,
    S_DIV_NF,
    S_WAIT_NF,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [THR_W-1:0]   threshold;
    logic [DATA_W-1:0]  gain;
    logic               smooth;
    logic [1:0]         norm;
    logic [BATCH_W-1:0] batch;
    logic               pos_src;
  } cfg_t;

  typedef struct packed {
    logic [MUL_AW-1:0] a;
    logic [MUL_BW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quotient;
  } div_rsp_t;

endpackage

[hdl/rla_in_if.sv]
// ----------------------------------------------------------------------------
// rla_in_if: input channel of the loss accumulator
// Carries one prediction and target word with its last-element flag.
// ----------------------------------------------------------------------------
interface rla_in_if;
  import rla_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] prediction;
  logic [DATA_W-1:0] target;
  logic              last_element;

  modport source (output valid, prediction, target, last_element, input ready);
  modport sink (input valid, prediction, target, last_element, output ready);
endinterface

[hdl/rla_out_if.sv]
// ----------------------------------------------------------------------------
// rla_out_if: result channel of the loss accumulator
// Carries one normalized loss word and its normalization factor.
// ----------------------------------------------------------------------------
interface rla_out_if;
  import rla_pkg::*;

  logic              valid;
  logic              ready;
  logic [LOSS_W-1:0] loss_value;
  logic [NORM_W-1:0] norm_factor;

  modport source (output valid, loss_value, norm_factor, input ready);
  modport sink (input valid, loss_value, norm_factor, output ready);
endinterface

[hdl/rla_apb_regs.sv]
// ----------------------------------------------------------------------------
// rla_apb_regs: configuration registers
// APB-style register file holding threshold, gain, loss mode, normalization
// mode, batch count and positive source.
// ----------------------------------------------------------------------------
module rla_apb_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rla_pkg::APB_AW-1:0] paddr,
  input  logic [rla_pkg::APB_DW-1:0] pwdata,
  output logic [rla_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output rla_pkg::cfg_t              cfg
);
  import rla_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= '0;
      cfg.gain      <= DATA_W'(ONE_Q);
      cfg.smooth    <= 1'b0;
      cfg.norm      <= NORM_NONE;
      cfg.batch     <= BATCH_W'(1);
      cfg.pos_src   <= 1'b1;
    end else if (wr) begin
      case (idx)
        REG_THRESHOLD: cfg.threshold <= pwdata[THR_W-1:0];
        REG_GAIN:      cfg.gain      <= pwdata[DATA_W-1:0];
        REG_SMOOTH:    cfg.smooth    <= pwdata[0];
        REG_NORM:      cfg.norm      <= pwdata[1:0];
        REG_BATCH:     cfg.batch     <= pwdata[BATCH_W-1:0];
        REG_POS_SRC:   cfg.pos_src   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_THRESHOLD: prdata = APB_DW'(cfg.threshold);
      REG_GAIN:      prdata = APB_DW'(cfg.gain);
      REG_SMOOTH:    prdata = APB_DW'(cfg.smooth);
      REG_NORM:      prdata = APB_DW'(cfg.norm);
      REG_BATCH:     prdata = APB_DW'(cfg.batch);
      REG_POS_SRC:   prdata = APB_DW'(cfg.pos_src);
      default:       prdata = '0;
    endcase
  end
endmodule

[hdl/rla_mul_unit.sv]
// ----------------------------------------------------------------------------
// rla_mul_unit: shared multiplier
// Unsigned 33 by 32 bit multiplier with a registered product, used for the
// gain scaling, the squaring and the batch rescaling.
// ----------------------------------------------------------------------------
module rla_mul_unit (
  input  logic                       clk,
  input  rla_pkg::mul_req_t          req,
  output logic [rla_pkg::MUL_PW-1:0] product
);
  import rla_pkg::*;

  always_ff @(posedge clk) begin
    product <= MUL_PW'(req.a) * MUL_PW'(req.b);
  end
endmodule

[hdl/rla_div_unit.sv]
// ----------------------------------------------------------------------------
// rla_div_unit: shared iterative divider
// Restoring divider that produces one quotient bit per cycle and pulses done
// when the full quotient is available.
// ----------------------------------------------------------------------------
module rla_div_unit (
  input  logic              clk,
  input  logic              rst,
  input  rla_pkg::div_req_t req,
  output rla_pkg::div_rsp_t rsp
);
  import rla_pkg::*;

  logic [DIV_DW-1:0]    rem;
  logic [DIV_DW-1:0]    dvsr;
  logic [DIV_NW-1:0]    quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 done;
  logic [DIV_DW:0]      trial;
  logic [DIV_DW:0]      diff;
  logic                 fits;

  always_comb begin
    trial = {rem, quo[DIV_NW-1]};
    diff  = trial - {1'b0, dvsr};
    fits  = trial >= {1'b0, dvsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == DIV_CNT_W'(1));
      if (req.start) begin
        cnt <= DIV_CNT_W'(DIV_NW);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      quo  <= req.dividend;
      dvsr <= req.divisor;
    end else if (cnt != '0) begin
      rem <= fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      quo <= {quo[DIV_NW-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;
endmodule

[hdl/regression_loss_accumulator_unit.sv]
// ----------------------------------------------------------------------------
// regression_loss_accumulator_unit: squared or smooth regression loss
// The sample channel takes prediction and target words in Q16.16; a word
// with last_element set closes the batch and produces one result word on
// the result channel with the normalized loss and its scale factor.
// Each sample word occupies the block through the accept step, the mask
// step, two passes through the shared multiplier and the accumulate step;
// sample ready is high only while the sequencer is idle.
// Closing a batch adds divisions on the shared one-bit-per-cycle divider:
// one in norm modes 0 and 3, up to three in norm mode 1, and three plus two
// multiplier passes in norm mode 2; the result register is then loaded once
// it is empty or its word is being taken.
// The result register holds its word until the receiver takes it; sample
// words keep being accepted meanwhile, and only a following batch close
// waits for the register to empty. Reset clears the sums, counts and result
// valid and sets the registers to their defaults. The user, not the block,
// must see that registers are written over the APB port only while idle.
// ----------------------------------------------------------------------------
module regression_loss_accumulator_unit (
  input  logic                       clk,
  input  logic                       rst,
  rla_in_if.sink                     sample,
  rla_out_if.source                  result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rla_pkg::APB_AW-1:0] paddr,
  input  logic [rla_pkg::APB_DW-1:0] pwdata,
  output logic [rla_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import rla_pkg::*;

  cfg_t     cfg;
  state_t   state;
  state_t   state_next;
  mul_req_t mul_req;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [MUL_PW-1:0]      mul_p;
  logic [DATA_W-1:0]      p_q;
  logic [DATA_W-1:0]      t_q;
  logic                   last_q;
  logic [MUL_AW-1:0]      dm_kept;
  logic [XM_W-1:0]        xm;
  logic [SUM_W-1:0]       loss_sum;
  logic [COUNT_WIDTH-1:0] element_total;
  logic [COUNT_WIDTH-1:0] positive_total;
  logic [DIV_NW-1:0]      loss_acc;
  logic [COUNT_WIDTH-1:0] ex;
  logic [MUL_PW-1:0]      prod_lo;
  logic [NORM_W-1:0]      nf;
  logic                   out_valid;
  logic [LOSS_W-1:0]      out_loss;
  logic [NORM_W-1:0]      out_nf;

  logic                   accept;
  logic                   emit_load;
  logic [DATA_W-1:0]      gmag;
  logic [BATCH_W-1:0]     bn;
  logic [DIV_DW-1:0]      pc;
  logic [MUL_AW-1:0]      d;
  logic [MUL_AW-1:0]      dm;
  logic [MUL_AW:0]        e;
  logic [MUL_AW:0]        em;
  logic [MUL_AW+4:0]      ten_em;
  logic [MUL_AW+4:0]      three_t;
  logic                   rel_ok;
  logic                   keep;
  logic [SUM_W-1:0]       term;
  logic [SUM_W:0]         sum_ext;
  logic [XM_W-1:0]        xm_now;
  logic [DIV_NW-1:0]      ex_shift;
  logic [DIV_NW-1:0]      scaled;

  rla_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rla_mul_unit u_mul (
    .clk     (clk),
    .req     (mul_req),
    .product (mul_p)
  );

  rla_div_unit u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign accept    = sample.valid && sample.ready;
  assign emit_load = (state == S_EMIT) && (!out_valid || result.ready);

  always_comb begin
    gmag    = cfg.gain[DATA_W-1] ? (~cfg.gain + DATA_W'(1)) : cfg.gain;
    bn      = (cfg.batch == '0) ? BATCH_W'(1) : cfg.batch;
    pc      = DIV_DW'(positive_total) + DIV_DW'(1);
    xm_now  = mul_p[MUL_PW-1:FRAC_BITS];

    d       = {p_q[DATA_W-1], p_q} - {t_q[DATA_W-1], t_q};
    dm      = d[MUL_AW-1] ? (~d + MUL_AW'(1)) : d;
    e       = {d[MUL_AW-1], d} - {t_q[DATA_W-1], t_q[DATA_W-1], t_q};
    em      = e[MUL_AW] ? (~e + (MUL_AW+1)'(1)) : e;
    ten_em  = (MUL_AW+5)'({em, 3'b000}) + (MUL_AW+5)'({em, 1'b0});
    three_t = (MUL_AW+5)'({t_q, 1'b0}) + (MUL_AW+5)'(t_q);
    rel_ok  = (t_q == '0) || (!t_q[DATA_W-1] && (ten_em > three_t));
    keep    = (cfg.threshold == '0) || ((dm > MUL_AW'(cfg.threshold)) && rel_ok);

    if (cfg.smooth) begin
      if (xm > XM_W'(ONE_Q)) begin
        term = SUM_W'(xm) - SUM_W'(ONE_Q >> 1);
      end else begin
        term = SUM_W'(mul_p >> (FRAC_BITS + 1));
      end
    end else if (xm[XM_W-1:DATA_W] != '0) begin
      term = '1;
    end else begin
      term = SUM_W'(mul_p >> FRAC_BITS);
    end
    sum_ext  = {1'b0, loss_sum} + {1'b0, term};
    ex_shift = DIV_NW'(ex) << FRAC_BITS;
    scaled   = DIV_NW'(prod_lo) + (DIV_NW'(mul_p) << DATA_W);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (accept) state_next = S_MASK;
      S_MASK:     state_next = S_MUL1;
      S_MUL1:     state_next = S_MUL2;
      S_MUL2:     state_next = S_ACC;
      S_ACC:      state_next = last_q ? S_DIV_SUM : S_IDLE;
      S_DIV_SUM:  state_next = S_WAIT_SUM;
      S_WAIT_SUM: begin
        if (div_rsp.done) begin
          if (cfg.norm == NORM_ELEM) begin
            state_next = S_DIV_EX;
          end else if (cfg.norm == NORM_POS) begin
            state_next = S_MUL_LO;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_DIV_EX:   state_next = S_WAIT_EX;
      S_WAIT_EX: begin
        if (div_rsp.done) begin
          state_next = (div_rsp.quotient == '0) ? S_EMIT : S_DIV_L;
        end
      end
      S_DIV_L:    state_next = S_WAIT_L;
      S_WAIT_L:   if (div_rsp.done) state_next = S_EMIT;
      S_MUL_LO:   state_next = S_MUL_HI;
      S_MUL_HI:   state_next = S_DIV_P;
      S_DIV_P:    state_next = S_WAIT_P;
      S_WAIT_P:   if (div_rsp.done) state_next = S_DIV_NF;
      S_DIV_NF:   state_next = S_WAIT_NF;
      S_WAIT_NF:  if (div_rsp.done) state_next = S_EMIT;
      S_EMIT:     if (emit_load) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    sample.ready     = (state == S_IDLE);
    mul_req.a        = dm_kept;
    mul_req.b        = gmag;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = DIV_DW'(bn);
    case (state)
      S_MUL2: begin
        mul_req.a = MUL_AW'(xm_now[DATA_W-1:0]);
        mul_req.b = xm_now[DATA_W-1:0];
      end
      S_MUL_LO: begin
        mul_req.a = MUL_AW'(loss_acc[DATA_W-1:0]);
        mul_req.b = MUL_BW'(bn);
      end
      S_MUL_HI: begin
        mul_req.a = MUL_AW'(loss_acc[2*DATA_W-1:DATA_W]);
        mul_req.b = MUL_BW'(bn);
      end
      S_DIV_SUM: begin
        div_req.start    = 1'b1;
        div_req.dividend = cfg.smooth ? DIV_NW'(loss_sum) : DIV_NW'(loss_sum >> 1);
      end
      S_DIV_EX: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_NW'(element_total);
      end
      S_DIV_L: begin
        div_req.start    = 1'b1;
        div_req.dividend = loss_acc;
        div_req.divisor  = DIV_DW'(ex);
      end
      S_DIV_P: begin
        div_req.start    = 1'b1;
        div_req.dividend = scaled;
        div_req.divisor  = pc;
      end
      S_DIV_NF: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_NW'(pc) << FRAC_BITS;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loss_sum       <= '0;
      element_total  <= '0;
      positive_total <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        if (element_total != '1) begin
          element_total <= element_total + 1'b1;
        end
        if (((cfg.pos_src ? sample.target : sample.prediction) != '0) &&
            (positive_total != '1)) begin
          positive_total <= positive_total + 1'b1;
        end
      end
      if (state == S_ACC) begin
        loss_sum <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
      end
      if (emit_load) begin
        loss_sum       <= '0;
        element_total  <= '0;
        positive_total <= '0;
        out_valid      <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_q    <= sample.prediction;
      t_q    <= sample.target;
      last_q <= sample.last_element;
    end
    if (state == S_MASK) begin
      dm_kept <= keep ? dm : '0;
    end
    if (state == S_MUL2) begin
      xm <= xm_now;
    end
    if (state == S_MUL_HI) begin
      prod_lo <= mul_p;
    end
    if (div_rsp.done) begin
      case (state)
        S_WAIT_SUM: begin
          loss_acc <= div_rsp.quotient;
          nf       <= ONE_Q;
        end
        S_WAIT_EX: begin
          ex <= div_rsp.quotient[COUNT_WIDTH-1:0];
          if (div_rsp.quotient == '0) begin
            loss_acc <= (loss_acc != '0) ? '1 : '0;
            nf       <= '0;
          end
        end
        S_WAIT_L: begin
          loss_acc <= div_rsp.quotient;
          nf <= (ex_shift > (DIV_NW'(NF_LIMIT) << FRAC_BITS)) ? NORM_MAX :
                ex_shift[NORM_W-1:0];
        end
        S_WAIT_P: loss_acc <= div_rsp.quotient;
        S_WAIT_NF: begin
          nf <= (div_rsp.quotient > DIV_NW'(NORM_MAX)) ? NORM_MAX :
                div_rsp.quotient[NORM_W-1:0];
        end
        default: ;
      endcase
    end
    if (emit_load) begin
      out_loss <= (loss_acc > DIV_NW'(LOSS_MAX)) ? LOSS_MAX : loss_acc[LOSS_W-1:0];
      out_nf   <= nf;
    end
  end

  assign result.valid       = out_valid;
  assign result.loss_value  = out_loss;
  assign result.norm_factor = out_nf;

  a_rise_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == S_EMIT))
    else $error("result valid rose outside the emit state");

  a_accept_to_mask: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_MASK))
    else $error("accepted word did not enter the mask step");

  a_clear_on_emit: assert property (@(posedge clk) disable iff (rst)
    emit_load |=> (loss_sum == '0) && (element_total == '0) && (positive_total == '0))
    else $error("batch state not cleared after emit");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_WAIT_SUM) || (state == S_WAIT_EX) ||
                     (state == S_WAIT_L) || (state == S_WAIT_P) ||
                     (state == S_WAIT_NF))
    else $error("divider finished outside a wait state");
endmodule

[bench/tb_regression_loss_accumulator_unit.sv]
// ----------------------------------------------------------------------------
// tb_regression_loss_accumulator_unit: self-checking bench of the loss unit
// A short table of directed sample words and register writes is followed by
// random phases, each with fresh register settings and random batches.
// Each result word is compared field by field with the oldest expected word.
// Expected words come from accumulate_loss, or from the table on typed rows.
// Register writes are read back. Sender and receiver idle at random.
// ----------------------------------------------------------------------------
module tb_regression_loss_accumulator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rla_pkg::*;

  localparam int          RANDOM_SAMPLES = 1250;
  localparam int          CYCLE_LIMIT    = 2_000_000;
  localparam int          SETTLE_CYCLES  = 16;
  localparam logic [63:0] SUM_MAX        = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] CNT_MAX        = (64'd1 << COUNT_WIDTH) - 64'd1;
  localparam logic [63:0] ONE64          = 64'd1 << FRAC_BITS;

  typedef struct packed {
    logic [LOSS_W-1:0] loss;
    logic [NORM_W-1:0] nf;
  } loss_word_t;

  typedef enum logic { ROW_ITEM, ROW_REG } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    reg_idx_t    idx;
    logic [31:0] value;
    logic [31:0] pred;
    logic [31:0] tgt;
    logic        last;
    logic        typed;
    loss_word_t  want;
  } row_t;

  localparam int ROWS = 33;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  rla_in_if  sample_ch ();
  rla_out_if result_ch ();

  regression_loss_accumulator_unit dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [THR_W-1:0]   thr_q;
  logic [DATA_W-1:0]  gain_q;
  logic               smooth_q;
  logic [1:0]         norm_q;
  logic [BATCH_W-1:0] batch_q;
  logic               pos_src_q;

  logic [63:0] loss_sum_q;
  logic [63:0] elem_cnt_q;
  logic [63:0] pos_cnt_q;

  loss_word_t expected_losses[$];

  int mismatches;
  int samples_sent;
  int losses_seen;
  int settings_used;
  int burst_left;
  int stall_left;
  int cycle_count;
  bit tx_steady;
  bit rx_steady;

  row_t plan [ROWS] = '{
    '{ROW_ITEM, REG_THRESHOLD, 32'h0, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1,
      '{48'h0, 32'h1_0000}},
    '{ROW_ITEM, REG_THRESHOLD, 32'h0, 32'h0002_0000, 32'h0000_0000, 1'b1, 1'b1,
      '{48'h2_0000, 32'h1_0000}},
    '{ROW_ITEM, REG_THRESHOLD, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0,
      '{48'h0, 32'h0}},
    '{ROW_ITEM, REG_THRESHOLD, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0,
      '{48'h0, 32'h0}},
    '{ROW_REG, REG_GAIN, 32'h8000_0000, 32'h0, 32'h0, 1'b0, 1'b0, '{48'h0, 32'h0}},
    '{ROW_ITEM, REG_THRESHOLD, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1,
      '{LOSS_MAX, 32'h1_0000}},
    '{ROW_REG, REG_GAIN, 32'h0001_0000, 32'h0, 32'h0, 1'b0, 1'b0, '{48'h0, 32'h0}},
    '{ROW_REG, REG_THRESHOLD, 32'h0001_0000, 32'h0, 32'h0, 1'b0, 1'b0, '{48'h0, 32'h0}},
    '{ROW_ITEM, REG_THRESHOLD, 32'h0, 32'h0003_0000, 32'h0000_0000, 1'b0, 1'b0,
      '{48'h0, 32'h0}},
    '{ROW_ITEM, REG_THRESHOLD, 32'h0, 32'h0003_0000, 32'hFFFF_0000, 1'b0, 1'b0,
      '{48'h0, 32'h0}},
    '{ROW_ITEM, REG_THRESHOLD, 32'h0, 32'h0005_0000, 32'h0001_0000, 1'b0, 1'b0,
      '{48'h0, 32'h0}},
    '{ROW_ITEM, REG_THRESHOLD, 32'h0, 32'h0000_8000, 32'h0000_0000, 1'b1, 1'b0,
      '{48'h0, 32'h0}},
    '{ROW_REG, REG_THRESHOLD, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, 1'b0, '{48'h0, 32'h0}},
    '{ROW_ITEM, REG_THRESHOLD, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1,
      '{48'h0, 32'h1_0000}},
    '{ROW_REG, REG_THRESHOLD, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, '{48'h0, 32'h0}},
    '{ROW_REG, REG_SMOOTH, 32'h1, 32'h0, 32'h0, 1'b0, 1'b0, '{48'h0, 32'h0}},
    '{ROW_ITEM, REG_THRESHOLD, 32'h0, 32'h0000_8000, 32'h0000_0000, 1'b0, 1'b0,
      '{48'h0, 32'h0}},
    '{ROW_ITEM, REG_THRESHOLD, 32'h0, 32'h0003_0000, 32'h0000_0000, 1'b0, 1'b0,
      '{48'h0, 32'h0}},
    '{ROW_ITEM, REG_THRESHOLD, 32'h0, 32'h0001_0000, 32'h0000_0000, 1'b1, 1'b0,
      '{48'h0, 32'h0}},
    '{ROW_REG, REG_NORM, 32'(NORM_ELEM), 32'h0, 32'h0, 1'b0, 1'b0, '{48'h0, 32'h0}},
    '{ROW_REG, REG_BATCH, 32'h2, 32'h0, 32'h0, 1'b0, 1'b0, '{48'h0, 32'h0}},
    '{ROW_ITEM, REG_THRESHOLD, 32'h0, 32'h0002_0000, 32'h0000_0000, 1'b1, 1'b1,
      '{LOSS_MAX, 32'h0}},
    '{ROW_ITEM, REG_THRESHOLD, 32'h0, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1,
      '{48'h0, 32'h0}},
    '{ROW_ITEM, REG_THRESHOLD, 32'h0, 32'h0004_0000, 32'h0000_0000, 1'b0, 1'b0,
      '{48'h0, 32'h0}},
    '{ROW_ITEM, REG_THRESHOLD, 32'h0, 32'h0001_0000, 32'h0000_0000, 1'b0, 1'b0,
      '{48'h0, 32'h0}},
    '{ROW_ITEM, REG_THRESHOLD, 32'h0, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0,
      '{48'h0, 32'h0}},
    '{ROW_REG, REG_NORM, 32'(NORM_POS), 32'h0, 32'h0, 1'b0, 1'b0, '{48'h0, 32'h0}},
    '{ROW_ITEM, REG_THRESHOLD, 32'h0, 32'h0002_0000, 32'h0001_0000, 1'b0, 1'b0,
      '{48'h0, 32'h0}},
    '{ROW_ITEM, REG_THRESHOLD, 32'h0, 32'h0001_0000, 32'h0000_0000, 1'b1, 1'b0,
      '{48'h0, 32'h0}},
    '{ROW_REG, REG_POS_SRC, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, '{48'h0, 32'h0}},
    '{ROW_ITEM, REG_THRESHOLD, 32'h0, 32'h0002_0000, 32'h0002_0000, 1'b1, 1'b0,
      '{48'h0, 32'h0}},
    '{ROW_REG, REG_NORM, 32'h3, 32'h0, 32'h0, 1'b0, 1'b0, '{48'h0, 32'h0}},
    '{ROW_REG, REG_BATCH, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, '{48'h0, 32'h0}}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d loss words outstanding", $time,
               expected_losses.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic [63:0] magnitude(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic bit accumulate_loss(input logic [31:0] pred, input logic [31:0] tgt,
                                         input logic last, output loss_word_t word);
    logic [63:0] p, t, d, dm, xm, term, s, bn, loss, nf, ex, pc, q, r, ip;
    bit keep;
    p = {{32{pred[31]}}, pred};
    t = {{32{tgt[31]}}, tgt};
    d = p - t;
    dm = magnitude(d);
    word = '0;
    if (thr_q != '0) begin
      keep = dm > {33'd0, thr_q};
      if (keep && t != 64'd0) begin
        if (t[63]) keep = 1'b0;
        else keep = (64'd10 * magnitude(d - t)) > (64'd3 * t);
      end
      if (!keep) dm = 64'd0;
    end
    xm = (dm * magnitude({{32{gain_q[31]}}, gain_q})) >> FRAC_BITS;
    if (smooth_q) begin
      term = (xm > ONE64) ? xm - (ONE64 >> 1) : (xm * xm) >> (FRAC_BITS + 1);
    end else begin
      term = (xm >= 64'h1_0000_0000) ? SUM_MAX : (xm * xm) >> FRAC_BITS;
    end
    s = loss_sum_q + term;
    loss_sum_q = (s < loss_sum_q) ? SUM_MAX : s;
    if (elem_cnt_q < CNT_MAX) elem_cnt_q++;
    if ((pos_src_q ? t : p) != 64'd0 && pos_cnt_q < CNT_MAX) pos_cnt_q++;
    if (!last) return 1'b0;

    bn = (batch_q == '0) ? 64'd1 : {48'd0, batch_q};
    loss = loss_sum_q / (smooth_q ? bn : bn * 64'd2);
    nf = ONE64;
    if (norm_q == NORM_ELEM) begin
      ex = elem_cnt_q / bn;
      if (ex == 64'd0) begin
        loss = (loss != 64'd0) ? SUM_MAX : 64'd0;
        nf = 64'd0;
      end else begin
        loss = loss / ex;
        nf = (ex > {32'd0, NF_LIMIT}) ? {32'd0, NORM_MAX} : ex << FRAC_BITS;
      end
    end else if (norm_q == NORM_POS) begin
      pc = pos_cnt_q + 64'd1;
      q = loss / pc;
      r = loss % pc;
      ip = pc / bn;
      if (q > SUM_MAX / bn) begin
        loss = SUM_MAX;
      end else begin
        s = q * bn + (r * bn) / pc;
        loss = (s < q * bn) ? SUM_MAX : s;
      end
      if (ip > {32'd0, NF_LIMIT}) begin
        nf = {32'd0, NORM_MAX};
      end else begin
        nf = (ip << FRAC_BITS) + (((pc % bn) << FRAC_BITS) / bn);
        if (nf > {32'd0, NORM_MAX}) nf = {32'd0, NORM_MAX};
      end
    end
    word.loss = (loss > {16'd0, LOSS_MAX}) ? LOSS_MAX : loss[LOSS_W-1:0];
    word.nf = nf[NORM_W-1:0];
    loss_sum_q = 64'd0;
    elem_cnt_q = 64'd0;
    pos_cnt_q = 64'd0;
    return 1'b1;
  endfunction

  always @(negedge clk) begin
    if (rx_steady || stall_left == 0) begin
      result_ch.ready = 1'b1;
      if (!rx_steady && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 15);
    end else begin
      result_ch.ready = 1'b0;
      stall_left--;
    end
  end

  always @(posedge clk) begin
    loss_word_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      losses_seen++;
      if (expected_losses.size() == 0) begin
        $display("%0t: unexpected loss word loss=%h nf=%h", $time,
                 result_ch.loss_value, result_ch.norm_factor);
        mismatches++;
      end else begin
        want = expected_losses.pop_front();
        if (result_ch.loss_value !== want.loss) begin
          $display("%0t: loss_value expected %h got %h", $time, want.loss,
                   result_ch.loss_value);
          mismatches++;
        end
        if (result_ch.norm_factor !== want.nf) begin
          $display("%0t: norm_factor expected %h got %h", $time, want.nf,
                   result_ch.norm_factor);
          mismatches++;
        end
      end
    end
  end

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] want;
    case (idx)
      REG_THRESHOLD: thr_q = value[THR_W-1:0];
      REG_GAIN:      gain_q = value;
      REG_SMOOTH:    smooth_q = value[0];
      REG_NORM:      norm_q = value[1:0];
      REG_BATCH:     batch_q = value[BATCH_W-1:0];
      REG_POS_SRC:   pos_src_q = value[0];
      default: ;
    endcase
    case (idx)
      REG_THRESHOLD: want = {1'b0, thr_q};
      REG_GAIN:      want = gain_q;
      REG_SMOOTH:    want = {31'd0, smooth_q};
      REG_NORM:      want = {30'd0, norm_q};
      REG_BATCH:     want = {16'd0, batch_q};
      default:       want = {31'd0, pos_src_q};
    endcase
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      $display("%0t: register %s read expected %h got %h", $time, idx.name(), want, prdata);
      mismatches++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic send_sample(input logic [31:0] pred, input logic [31:0] tgt,
                             input logic last, input logic typed, input loss_word_t want);
    loss_word_t predicted;
    if (!tx_steady && burst_left == 0) begin
      sample_ch.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    sample_ch.valid = 1'b1;
    sample_ch.prediction = pred;
    sample_ch.target = tgt;
    sample_ch.last_element = last;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    if (accumulate_loss(pred, tgt, last, predicted)) begin
      expected_losses.push_back(typed ? want : predicted);
    end
    if (burst_left != 0) burst_left--;
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    sample_ch.valid = 1'b0;
    while (expected_losses.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (!sample_ch.ready) @(negedge clk);
  endtask

  function automatic logic [31:0] random_value();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h0;
      1: v = 32'h7FFF_FFFF;
      2: v = 32'h8000_0000;
      3, 4: v = $urandom;
      default: begin
        v = $urandom_range(0, 32'h0008_0000);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic random_settings();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = 32'h0;
      4, 5, 6: v = $urandom_range(1, 32'h0004_0000);
      7: v = 32'h7FFF_FFFF;
      default: v = $urandom & 32'h7FFF_FFFF;
    endcase
    reg_write(REG_THRESHOLD, v);
    case ($urandom_range(0, 9))
      0, 1, 2: v = 32'h0001_0000;
      3: v = 32'h8000_0000;
      4: v = 32'h7FFF_FFFF;
      5: v = 32'h0;
      6, 7: begin
        v = $urandom_range(0, 32'h0004_0000);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = $urandom;
    endcase
    reg_write(REG_GAIN, v);
    reg_write(REG_SMOOTH, 32'($urandom_range(0, 1)));
    reg_write(REG_NORM, 32'($urandom_range(0, 3)));
    case ($urandom_range(0, 9))
      0: v = 32'h0;
      1: v = 32'hFFFF;
      2, 3: v = 32'h1;
      default: v = $urandom_range(1, 8);
    endcase
    reg_write(REG_BATCH, v);
    reg_write(REG_POS_SRC, 32'($urandom_range(0, 1)));
    settings_used++;
  endtask

  initial begin
    int random_sent;
    int phase_target;
    int phase_sent;
    int batch_len;
    logic [31:0] pred;
    logic [31:0] tgt;
    logic [31:0] delta;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_ch.valid = 1'b0;
    sample_ch.prediction = '0;
    sample_ch.target = '0;
    sample_ch.last_element = 1'b0;
    result_ch.ready = 1'b0;
    thr_q = '0;
    gain_q = 32'h0001_0000;
    smooth_q = 1'b0;
    norm_q = NORM_NONE;
    batch_q = 16'd1;
    pos_src_q = 1'b1;
    loss_sum_q = '0;
    elem_cnt_q = '0;
    pos_cnt_q = '0;
    random_sent = 0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < ROWS; i++) begin
      if (plan[i].kind == ROW_REG) begin
        settle();
        reg_write(plan[i].idx, plan[i].value);
      end else begin
        send_sample(plan[i].pred, plan[i].tgt, plan[i].last, plan[i].typed, plan[i].want);
      end
    end

    while (random_sent < RANDOM_SAMPLES) begin
      settle();
      random_settings();
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      phase_target = $urandom_range(30, 90);
      phase_sent = 0;
      while (phase_sent < phase_target) begin
        case ($urandom_range(0, 19))
          0: batch_len = 1;
          1, 2: batch_len = $urandom_range(11, 40);
          default: batch_len = $urandom_range(1, 10);
        endcase
        for (int k = 0; k < batch_len; k++) begin
          tgt = random_value();
          if ($urandom_range(0, 4) == 0) begin
            delta = $urandom_range(0, 32'h0002_0000);
            if ($urandom_range(0, 1) == 1) delta = -delta;
            pred = tgt + delta;
          end else begin
            pred = random_value();
          end
          send_sample(pred, tgt, k == batch_len - 1, 1'b0, '0);
          phase_sent++;
          random_sent++;
        end
      end
    end

    sample_ch.valid = 1'b0;
    rx_steady = 1'b0;
    while (expected_losses.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("Sent %0d sample words under %0d register settings; checked %0d loss words.",
             samples_sent, settings_used, losses_seen);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0 && expected_losses.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/rla_pkg.sv
hdl/rla_in_if.sv
hdl/rla_out_if.sv
hdl/rla_apb_regs.sv
hdl/rla_mul_unit.sv
hdl/rla_div_unit.sv
hdl/regression_loss_accumulator_unit.sv
bench/tb_regression_loss_accumulator_unit.sv
